/* hw/rtl/sfig_pkg.sv */
`default_nettype none

package sfig_pkg;

	// sizes of the payload
	localparam int SAMPLE_BITS = 16;
	localparam int KNOB_W      = 16;
	localparam int RATE_W      = 18;
	localparam int GAIN_W      = 17;
	localparam int FLASH_W     = 15;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 18;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FADE_TIME = 2'd0,
		CFG_SHAPE     = 2'd1,
		CFG_RATE      = 2'd2
	} cfg_reg_t;

	localparam logic [KNOB_W-1:0] SHAPE_RESET = 16'd32768;
	localparam logic [RATE_W-1:0] RATE_RESET  = 18'd48000;

	// ramp progress q1.24 and gain q1.16
	localparam int PROG_W    = 25;
	localparam int PROG_FRAC = 24;
	localparam logic [PROG_W-1:0] ONE_Q24 = 25'h100_0000;
	localparam logic [GAIN_W-1:0] ONE_Q16 = 17'h1_0000;

	// log curve table, depth is a power of two
	localparam int LOG_TABLE_DEPTH = 1024;
	localparam int LOG_IDX_W       = $clog2(LOG_TABLE_DEPTH);
	localparam int LOG_FRAC_W      = PROG_FRAC - LOG_IDX_W;
	localparam int LOG_DATA_W      = 16;

	typedef logic [LOG_DATA_W-1:0] log_rom_t [LOG_TABLE_DEPTH];

	localparam logic [63:0] LOG_DEPTH_64 = 64'(LOG_TABLE_DEPTH);
	localparam logic [63:0] LOG_TWO_Q30  = 64'd2 << 30;
	localparam logic [63:0] LOG10_2_Q32  = 64'd1292913986;

	// ramp step = STEP_NUM / (rate * (FK_BASE + FK_SCALE * knob))
	localparam int FK_W     = 21;
	localparam int DEN_W    = 39;
	localparam int DIV_BITS = 26;
	localparam int DIV_CNT_W = $clog2(DIV_BITS);
	localparam logic [FK_W-1:0] FK_BASE  = 21'd65535;
	localparam logic [FK_W-1:0] FK_SCALE = 21'd19;
	localparam logic [40:0] STEP_NUM = 41'd131070 << 24;
	localparam logic [DIV_BITS-1:0] STEP_NUM_LO = STEP_NUM[DIV_BITS-1:0];
	localparam logic [DEN_W-1:0] STEP_NUM_HI = DEN_W'(STEP_NUM >> DIV_BITS);

	// floor(rate / 10) by reciprocal, exact for all 18 bit rates
	localparam logic [RATE_W-1:0] DIV10_MULT = 18'd209716;
	localparam int DIV10_SHIFT = 21;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_START,
		ST_DEN,
		ST_DIV,
		ST_ADVANCE,
		ST_LOOKUP,
		ST_INTERP,
		ST_BLEND,
		ST_SCALE
	} ctrl_state_t;

	typedef struct packed {
		logic                 accept;
		logic                 den_load;
		logic                 div_step;
		logic [DIV_CNT_W-1:0] div_bit;
		logic                 advance;
		logic                 rom_read;
		logic                 interp;
		logic                 blend;
		logic                 load_out;
	} sfig_cmd_t;

	typedef struct packed {
		logic ramp_on;
	} sfig_stat_t;

	// floor(65536*log10(1+9i/depth)) for every entry
	function automatic log_rom_t build_log_rom();
		log_rom_t    rom;
		logic [63:0] y;
		logic [63:0] ip;
		logic [63:0] fr;
		logic [63:0] r;
		for (int i = 0; i < LOG_TABLE_DEPTH; i++) begin
			y  = ((LOG_DEPTH_64 + 64'd9 * 64'(i)) << 30) / LOG_DEPTH_64;
			ip = 64'd0;
			fr = 64'd0;
			for (int k = 0; k < 4; k++) begin
				if (y >= LOG_TWO_Q30) begin
					y  = y >> 1;
					ip = ip + 64'd1;
				end
			end
			for (int b = 23; b >= 0; b--) begin
				y = (y * y) >> 30;
				if (y >= LOG_TWO_Q30) begin
					y     = y >> 1;
					fr[b] = 1'b1;
				end
			end
			r = (((ip << 24) | fr) * LOG10_2_Q32) >> 40;
			rom[i] = (r > 64'd65535) ? 16'hFFFF : r[15:0];
		end
		return rom;
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/sfig_log_rom.sv */
`default_nettype none

module sfig_log_rom
	import sfig_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  rd_en,
	input  wire logic [LOG_IDX_W-1:0]  addr,
	output logic      [LOG_DATA_W-1:0] lo_data,
	output logic      [GAIN_W-1:0]     hi_data
);

	localparam log_rom_t LOG_ROM = build_log_rom();
	localparam logic [LOG_IDX_W-1:0] LAST_ADDR = LOG_IDX_W'(LOG_TABLE_DEPTH - 1);

	logic [LOG_DATA_W-1:0] lo_q;
	logic [GAIN_W-1:0]     hi_q;
	logic [LOG_IDX_W-1:0]  addr_nx;

	assign addr_nx = addr + 1'b1;

	// entry and its right neighbor, 1.0 past the last entry
	always_ff @(posedge clk) begin
		if (rd_en) begin
			lo_q <= LOG_ROM[addr];
			if (addr == LAST_ADDR) begin
				hi_q <= ONE_Q16;
			end else begin
				hi_q <= {1'b0, LOG_ROM[addr_nx]};
			end
		end
	end

	assign lo_data = lo_q;
	assign hi_data = hi_q;

endmodule

`default_nettype wire

/* hw/rtl/sfig_ctrl.sv */
`default_nettype none

module sfig_ctrl
	import sfig_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  wire logic       out_ready,
	input  wire sfig_stat_t status,
	output sfig_cmd_t       cmd
);

	ctrl_state_t          state_q;
	ctrl_state_t          state_nx;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic                 out_valid_q;
	logic                 slot_free;

	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_nx = ST_START;
				end
			end
			ST_START: begin
				state_nx = status.ramp_on ? ST_DEN : ST_SCALE;
			end
			ST_DEN: begin
				state_nx = ST_DIV;
			end
			ST_DIV: begin
				if (div_cnt_q == '0) begin
					state_nx = ST_ADVANCE;
				end
			end
			ST_ADVANCE: begin
				state_nx = ST_LOOKUP;
			end
			ST_LOOKUP: begin
				state_nx = ST_INTERP;
			end
			ST_INTERP: begin
				state_nx = ST_BLEND;
			end
			ST_BLEND: begin
				state_nx = ST_SCALE;
			end
			ST_SCALE: begin
				if (slot_free) begin
					state_nx = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready     = 1'b0;
		cmd          = '0;
		cmd.div_bit  = div_cnt_q;
		case (state_q)
			ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
			end
			ST_DEN: begin
				cmd.den_load = 1'b1;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
			end
			ST_ADVANCE: begin
				cmd.advance = 1'b1;
			end
			ST_LOOKUP: begin
				cmd.rom_read = 1'b1;
			end
			ST_INTERP: begin
				cmd.interp = 1'b1;
			end
			ST_BLEND: begin
				cmd.blend = 1'b1;
			end
			ST_SCALE: begin
				cmd.load_out = slot_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			div_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (state_q == ST_DEN) begin
				div_cnt_q <= DIV_CNT_W'(DIV_BITS - 1);
			end else if (state_q == ST_DIV) begin
				div_cnt_q <= div_cnt_q - 1'b1;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

/* hw/rtl/sfig_datapath.sv */
`default_nettype none

module sfig_datapath
	import sfig_pkg::*;
(
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic        [CFG_IDX_W-1:0]   cfg_index,
	input  wire logic        [CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                          fade_button,
	input  wire logic                          reset_button,
	input  wire logic signed [SAMPLE_BITS-1:0] left_in,
	input  wire logic signed [SAMPLE_BITS-1:0] right_in,
	input  wire logic                          right_patched,
	input  wire sfig_cmd_t                     cmd,
	output sfig_stat_t                         status,
	output logic signed      [SAMPLE_BITS-1:0] left_out,
	output logic signed      [SAMPLE_BITS-1:0] right_out,
	output logic             [GAIN_W-1:0]      gain_level,
	output logic                               reset_led,
	output logic                               fading
);

	localparam int SCALE_W = SAMPLE_BITS + GAIN_W + 1;
	localparam logic signed [SCALE_W-1:0] SAT_HI = SCALE_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 1);
	localparam logic signed [SCALE_W-1:0] SAT_LO = -SCALE_W'(64'sd1 <<< (SAMPLE_BITS - 1));
	localparam int R10_W = RATE_W + RATE_W;

	// configuration
	logic [KNOB_W-1:0] fade_knob_q;
	logic [KNOB_W-1:0] shape_knob_q;
	logic [RATE_W-1:0] rate_q;

	// block state
	logic               prev_fade_q;
	logic               prev_rst_q;
	logic               active_q;
	logic [PROG_W-1:0]  progress_q;
	logic [GAIN_W-1:0]  gain_q;
	logic [FLASH_W-1:0] flash_q;
	logic               led_q;

	// per request work registers
	logic signed [SAMPLE_BITS-1:0] left_q;
	logic signed [SAMPLE_BITS-1:0] right_q;
	logic [DEN_W-1:0]    den_q;
	logic [DEN_W-1:0]    rem_q;
	logic [DIV_BITS-1:0] quo_q;
	logic                top_q;
	logic [GAIN_W-1:0]   lg_q;

	// result registers
	logic signed [SAMPLE_BITS-1:0] left_out_q;
	logic signed [SAMPLE_BITS-1:0] right_out_q;
	logic [GAIN_W-1:0]             gain_out_q;
	logic                          led_out_q;
	logic                          fading_out_q;

	logic                  fade_edge;
	logic                  rst_edge;
	logic [RATE_W-1:0]     rate_eff;
	logic [R10_W-1:0]      r10_prod;
	logic [FLASH_W-1:0]    flash_cur;
	logic [FK_W-1:0]       fk;
	logic [DEN_W-1:0]      den_d;
	logic [DEN_W:0]        trial;
	logic [PROG_W+1:0]     prog_sum;
	logic [LOG_IDX_W:0]    idx_full;
	logic [LOG_DATA_W-1:0] rom_lo;
	logic [GAIN_W-1:0]     rom_hi;
	logic [GAIN_W-1:0]     lg_diff;
	logic [GAIN_W+LOG_FRAC_W-1:0] lg_prod;
	logic [GAIN_W-1:0]     lin;
	logic signed [GAIN_W:0]       blend_diff;
	logic signed [KNOB_W-1:0]     shape_s;
	logic signed [GAIN_W+KNOB_W:0] blend_prod;
	logic signed [GAIN_W+1:0]     gain_sum;
	logic [GAIN_W-1:0]            gain_d;

	function automatic logic signed [SAMPLE_BITS-1:0] scale_sample(
		input logic signed [SAMPLE_BITS-1:0] x,
		input logic        [GAIN_W-1:0]      g
	);
		logic signed [GAIN_W:0]    gs;
		logic signed [SCALE_W-1:0] p;
		logic signed [SCALE_W-1:0] sh;
		gs = $signed({1'b0, g});
		p  = x * gs;
		sh = p >>> 16;
		if (sh > SAT_HI) begin
			return SAT_HI[SAMPLE_BITS-1:0];
		end else if (sh < SAT_LO) begin
			return SAT_LO[SAMPLE_BITS-1:0];
		end
		return sh[SAMPLE_BITS-1:0];
	endfunction

	assign fade_edge = fade_button && !prev_fade_q;
	assign rst_edge  = reset_button && !prev_rst_q;
	assign rate_eff  = (rate_q == '0) ? RATE_W'(1) : rate_q;

	// flash length on a reset edge
	assign r10_prod  = rate_eff * DIV10_MULT;
	assign flash_cur = rst_edge ? r10_prod[DIV10_SHIFT +: FLASH_W] : flash_q;

	// divisor for the ramp step
	assign fk    = FK_BASE + FK_W'(fade_knob_q) * FK_SCALE;
	assign den_d = rate_eff * fk;
	assign trial = {rem_q, STEP_NUM_LO[cmd.div_bit]};

	assign prog_sum = {2'b00, progress_q} + {1'b0, quo_q};

	// table position
	assign idx_full = progress_q[PROG_W-1:LOG_FRAC_W];

	sfig_log_rom u_log_rom (
		.clk     (clk),
		.rd_en   (cmd.rom_read),
		.addr    (idx_full[LOG_IDX_W-1:0]),
		.lo_data (rom_lo),
		.hi_data (rom_hi)
	);

	assign lg_diff = rom_hi - {1'b0, rom_lo};
	assign lg_prod = lg_diff * progress_q[LOG_FRAC_W-1:0];

	// blend of linear and log curves
	assign lin        = progress_q[PROG_W-1:PROG_FRAC-16];
	assign blend_diff = $signed({1'b0, lg_q}) - $signed({1'b0, lin});
	assign shape_s    = $signed({~shape_knob_q[KNOB_W-1], shape_knob_q[KNOB_W-2:0]});
	assign blend_prod = blend_diff * shape_s;
	assign gain_sum   = $signed({2'b00, lin}) + blend_prod[GAIN_W+KNOB_W:15];

	always_comb begin
		if (gain_sum < 0) begin
			gain_d = '0;
		end else if (gain_sum > $signed({2'b00, ONE_Q16})) begin
			gain_d = ONE_Q16;
		end else begin
			gain_d = gain_sum[GAIN_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fade_knob_q  <= '0;
			shape_knob_q <= SHAPE_RESET;
			rate_q       <= RATE_RESET;
			prev_fade_q  <= 1'b0;
			prev_rst_q   <= 1'b0;
			active_q     <= 1'b0;
			progress_q   <= '0;
			gain_q       <= '0;
			flash_q      <= '0;
			led_q        <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_FADE_TIME: fade_knob_q  <= cfg_data[KNOB_W-1:0];
					CFG_SHAPE:     shape_knob_q <= cfg_data[KNOB_W-1:0];
					CFG_RATE:      rate_q       <= cfg_data[RATE_W-1:0];
					default:       rate_q       <= rate_q;
				endcase
			end
			if (cmd.accept) begin
				prev_fade_q <= fade_button;
				prev_rst_q  <= reset_button;
				// fade restart wins over reset
				if (fade_edge) begin
					active_q <= 1'b1;
				end else if (rst_edge) begin
					active_q <= 1'b0;
				end
				if (fade_edge || rst_edge) begin
					progress_q <= '0;
					gain_q     <= '0;
				end
				led_q   <= (flash_cur != '0);
				flash_q <= flash_cur - FLASH_W'(flash_cur != '0);
			end
			if (cmd.advance) begin
				if (prog_sum >= {2'b00, ONE_Q24}) begin
					progress_q <= ONE_Q24;
					active_q   <= 1'b0;
				end else begin
					progress_q <= prog_sum[PROG_W-1:0];
				end
			end
			if (cmd.blend) begin
				gain_q <= gain_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			left_q  <= left_in;
			right_q <= right_patched ? right_in : left_in;
		end
		if (cmd.den_load) begin
			den_q <= den_d;
			rem_q <= STEP_NUM_HI;
		end
		// one quotient bit per cycle
		if (cmd.div_step) begin
			if (trial >= {1'b0, den_q}) begin
				rem_q <= DEN_W'(trial - {1'b0, den_q});
				quo_q <= {quo_q[DIV_BITS-2:0], 1'b1};
			end else begin
				rem_q <= trial[DEN_W-1:0];
				quo_q <= {quo_q[DIV_BITS-2:0], 1'b0};
			end
		end
		if (cmd.rom_read) begin
			top_q <= idx_full[LOG_IDX_W];
		end
		if (cmd.interp) begin
			if (top_q) begin
				lg_q <= ONE_Q16;
			end else begin
				lg_q <= {1'b0, rom_lo} + lg_prod[LOG_FRAC_W +: GAIN_W];
			end
		end
		if (cmd.load_out) begin
			left_out_q   <= scale_sample(left_q, gain_q);
			right_out_q  <= scale_sample(right_q, gain_q);
			gain_out_q   <= gain_q;
			led_out_q    <= led_q;
			fading_out_q <= active_q;
		end
	end

	assign status.ramp_on = active_q;
	assign left_out       = left_out_q;
	assign right_out      = right_out_q;
	assign gain_level     = gain_out_q;
	assign reset_led      = led_out_q;
	assign fading         = fading_out_q;

endmodule

`default_nettype wire

/* hw/rtl/stereo_shaped_fade_in_gain.sv */
`default_nettype none

// Stereo fade-in gain with a shaped curve. Each request carries one stereo
// sample and the fade and reset button levels; each gives exactly one result
// with both channels scaled by the current gain (q1.16, saturated), the gain
// itself, the reset LED and the ramp flag. A rising fade edge restarts the
// ramp from silence, a rising reset edge stops it at zero gain and flashes
// the LED for rate/10 samples; with both edges at once the fade wins. The
// ramp length comes from fade_time_knob (0.5 s to 10 s), the curve from
// shape_knob (0 log-inverse, 32768 linear, 65535 near log10(1+9t)), and
// sample_rate_hz sets both ramp step and flash length. Configuration is
// to be written through cfg_we/cfg_index/cfg_data only while no request is
// in flight; the block does not enforce this. With no ramp running, a
// request goes from accepting straight to scaling; while it ramps, a
// bit-serial divider first derives the ramp step from the rate and fade
// time, then the progress advances and the table is read, interpolated and
// blended before the scaling. A finished result waits in the output
// register, and the next request is taken while it waits; that request then
// holds in its last step until the waiting result has been taken.
module stereo_shaped_fade_in_gain
	import sfig_pkg::*;
(
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// configuration writes
	input  wire logic                          cfg_we,
	input  wire logic        [CFG_IDX_W-1:0]   cfg_index,
	input  wire logic        [CFG_DATA_W-1:0]  cfg_data,
	// input requests
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic                          fade_button,
	input  wire logic                          reset_button,
	input  wire logic signed [SAMPLE_BITS-1:0] left_in,
	input  wire logic signed [SAMPLE_BITS-1:0] right_in,
	input  wire logic                          right_patched,
	// result requests
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic signed      [SAMPLE_BITS-1:0] left_out,
	output logic signed      [SAMPLE_BITS-1:0] right_out,
	output logic             [GAIN_W-1:0]      gain_level,
	output logic                               reset_led,
	output logic                               fading
);

	// commands from the sequencer, ramp status back
	sfig_cmd_t  cmd;
	sfig_stat_t status;

	// sequencer: accept, step divide, table lookup, blend, scale, hand off
	sfig_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	// config registers, ramp state, divider, log table, multipliers
	sfig_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.fade_button   (fade_button),
		.reset_button  (reset_button),
		.left_in       (left_in),
		.right_in      (right_in),
		.right_patched (right_patched),
		.cmd           (cmd),
		.status        (status),
		.left_out      (left_out),
		.right_out     (right_out),
		.gain_level    (gain_level),
		.reset_led     (reset_led),
		.fading        (fading)
	);

`ifndef SYNTH
	// gain clamp keeps the result inside unity
	a_gain_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (gain_level <= ONE_Q16))
		else $error("gain above unity");

	// one request in flight at a time
	a_one_req: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("second request taken while busy");

	// a loaded result must not be overwritten while it waits
	a_hold_out: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |-> !cmd.load_out)
		else $error("result overwritten before hand off");
`endif

endmodule

`default_nettype wire

/* bench/stereo_shaped_fade_in_gain_tb.sv */
`default_nettype none

module stereo_shaped_fade_in_gain_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import sfig_pkg::*;

	// run limits
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int DRAIN_CYCLES = 40;    // longer than a ramping request takes
	localparam int PRINT_LIMIT  = 50;

	// fixed point anchors kept local to the bench
	localparam longint PROGRESS_ONE = longint'(1) << 24;
	localparam longint GAIN_ONE     = 65536;
	localparam int     CURVE_DEPTH  = 1024;
	localparam bit [63:0] LOG10_OF_2_Q32 = 64'd1292913986;

	// one expected result
	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] left_out;
		logic signed [SAMPLE_BITS-1:0] right_out;
		logic [GAIN_W-1:0]             gain_level;
		logic                          reset_led;
		logic                          fading;
	} gain_result_t;

	// clock and reset
	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	// configuration port
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	// input requests
	logic                          in_valid      = 1'b0;
	logic                          in_ready;
	logic                          fade_button   = 1'b0;
	logic                          reset_button  = 1'b0;
	logic signed [SAMPLE_BITS-1:0] left_in       = '0;
	logic signed [SAMPLE_BITS-1:0] right_in      = '0;
	logic                          right_patched = 1'b0;

	// result requests
	logic                          out_valid;
	logic                          out_ready = 1'b0;
	logic signed [SAMPLE_BITS-1:0] left_out;
	logic signed [SAMPLE_BITS-1:0] right_out;
	logic [GAIN_W-1:0]             gain_level;
	logic                          reset_led;
	logic                          fading;

	// bench bookkeeping
	gain_result_t pending_results[$];
	int           error_count  = 0;
	int           result_count = 0;
	int           cycle_count  = 0;
	bit           quiet_mode   = 1'b0;   // no random idling on either side while set
	int           hold_request = 0;      // long receiver hold asked by a test
	int           stall_left   = 0;

	// button levels as the stimulus sees them
	bit fade_lvl  = 1'b0;
	bit reset_lvl = 1'b0;

	// predictor copy of the configuration, at reset values
	logic [15:0] fade_knob_cfg = 16'd0;
	logic [15:0] shape_cfg     = 16'd32768;
	logic [17:0] rate_cfg      = 18'd48000;

	// predictor copy of the block state
	bit          fade_was   = 1'b0;
	bit          reset_was  = 1'b0;
	bit          ramp_on    = 1'b0;
	longint      ramp_pos   = 0;     // q1.24
	longint      held_gain  = 0;     // q1.16
	longint      flash_left = 0;
	logic [15:0] log_curve_rom [CURVE_DEPTH];

	stereo_shaped_fade_in_gain dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.fade_button  (fade_button),
		.reset_button (reset_button),
		.left_in      (left_in),
		.right_in     (right_in),
		.right_patched(right_patched),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.left_out     (left_out),
		.right_out    (right_out),
		.gain_level   (gain_level),
		.reset_led    (reset_led),
		.fading       (fading)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// overall watchdog
	always @(posedge clk) begin
		cycle_count = cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("== FAIL ==");
			$finish;
		end
	end

	// gap lengths: mostly none or short, now and then long
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (quiet_mode || roll < 55)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// floor(65536*log10(1+9i/depth)), found by repeated squaring in q30
	function automatic void fill_log_curve();
		bit [63:0] y;
		bit [63:0] whole;
		bit [63:0] part;
		bit [63:0] prod;
		for (int i = 0; i < CURVE_DEPTH; i++) begin
			y     = ((64'(CURVE_DEPTH) + 64'd9 * 64'(i)) << 30) / 64'(CURVE_DEPTH);
			whole = 0;
			part  = 0;
			while (y >= (64'd2 << 30)) begin
				y     = y >> 1;
				whole = whole + 1;
			end
			for (int b = 23; b >= 0; b--) begin
				y = (y * y) >> 30;
				if (y >= (64'd2 << 30)) begin
					y       = y >> 1;
					part[b] = 1'b1;
				end
			end
			prod = (((whole << 24) | part) * LOG10_OF_2_Q32) >> 40;
			log_curve_rom[i] = (prod > 64'd65535) ? 16'hFFFF : prod[15:0];
		end
	endfunction

	// log curve at a q1.24 progress, interpolated, 65536 past the last entry
	function automatic longint log_curve_at(input longint progress);
		longint pos;
		longint idx;
		longint frac;
		longint lo;
		longint hi;
		pos  = progress * CURVE_DEPTH;
		idx  = pos >>> 24;
		frac = pos & 64'hFF_FFFF;
		if (idx >= CURVE_DEPTH)
			return GAIN_ONE;
		lo = log_curve_rom[idx];
		hi = (idx + 1 < CURVE_DEPTH) ? longint'(log_curve_rom[idx + 1]) : GAIN_ONE;
		return lo + (((hi - lo) * frac) >>> 24);
	endfunction

	// sample times gain, floored by 16 bits and clamped
	function automatic logic signed [SAMPLE_BITS-1:0] scale_sample(input longint x,
			input longint g);
		longint v;
		longint top;
		top = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
		v   = (x * g) >>> 16;
		if (v > top)
			v = top;
		if (v < -top - 1)
			v = -top - 1;
		return v[SAMPLE_BITS-1:0];
	endfunction

	// next expected result, advancing the bench copy of the state
	function automatic gain_result_t predict_gain_stage(input bit fb, input bit rb,
			input logic signed [SAMPLE_BITS-1:0] l, input logic signed [SAMPLE_BITS-1:0] r,
			input bit patched);
		gain_result_t res;
		longint rate;
		longint den;
		longint step;
		longint lin;
		longint lg;
		longint s;
		longint g;
		longint lx;
		longint rx;
		rate = (rate_cfg == 0) ? 1 : longint'(rate_cfg);
		lx   = l;
		rx   = patched ? longint'(r) : longint'(l);
		// reset edge first so that a fade edge in the same request wins
		if (rb && !reset_was) begin
			ramp_on    = 1'b0;
			ramp_pos   = 0;
			held_gain  = 0;
			flash_left = rate / 10;
		end
		if (fb && !fade_was) begin
			ramp_on   = 1'b1;
			ramp_pos  = 0;
			held_gain = 0;
		end
		fade_was  = fb;
		reset_was = rb;
		if (ramp_on) begin
			den  = rate * (65535 + 19 * longint'(fade_knob_cfg));
			step = (longint'(131070) << 24) / den;
			ramp_pos = ramp_pos + step;
			if (ramp_pos >= PROGRESS_ONE) begin
				ramp_pos = PROGRESS_ONE;
				ramp_on  = 1'b0;
			end
			lin = ramp_pos >>> 8;
			lg  = log_curve_at(ramp_pos);
			s   = longint'(shape_cfg) - 32768;
			g   = lin + (((lg - lin) * s) >>> 15);
			if (g < 0)
				g = 0;
			if (g > GAIN_ONE)
				g = GAIN_ONE;
			held_gain = g;
		end
		res.reset_led = (flash_left != 0);
		if (flash_left != 0)
			flash_left = flash_left - 1;
		res.left_out   = scale_sample(lx, held_gain);
		res.right_out  = scale_sample(rx, held_gain);
		res.gain_level = held_gain[GAIN_W-1:0];
		res.fading     = ramp_on;
		return res;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		if (error_count < PRINT_LIMIT)
			$display("mismatch on result %0d, %s: got %0d, expected %0d",
				result_count, what, got, want);
		error_count++;
	endtask

	// one request: optional gap, then hold it until the block takes it
	task automatic send_sample(input bit fb, input bit rb,
			input logic signed [SAMPLE_BITS-1:0] l, input logic signed [SAMPLE_BITS-1:0] r,
			input bit patched);
		int gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
			@(negedge clk);
		end
		fade_button   <= fb;
		reset_button  <= rb;
		left_in       <= l;
		right_in      <= r;
		right_patched <= patched;
		in_valid      <= 1'b1;
		do @(posedge clk); while (in_ready !== 1'b1);
		pending_results.push_back(predict_gain_stage(fb, rb, l, r, patched));
	endtask

	// stop offering and let every outstanding result come back
	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_FADE_TIME: fade_knob_cfg = val[15:0];
			CFG_SHAPE:     shape_cfg     = val[15:0];
			CFG_RATE:      rate_cfg      = val[17:0];
			default:       ;
		endcase
	endtask

	// new settings only with the block idle
	task automatic set_config(input int unsigned knob, input int unsigned shape,
			input int unsigned rate);
		wait_drained();
		write_reg(CFG_FADE_TIME, CFG_DATA_W'(knob));
		write_reg(CFG_SHAPE, CFG_DATA_W'(shape));
		write_reg(CFG_RATE, CFG_DATA_W'(rate));
	endtask

	// random sample, extremes now and then
	function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
		case ($urandom_range(0, 11))
			0:       return 16'sh8000;
			1:       return 16'sh7FFF;
			2:       return 16'sh0000;
			3:       return 16'shFFFF;
			default: return SAMPLE_BITS'($urandom());
		endcase
	endfunction

	function automatic bit next_level(input bit lvl, input int pct);
		return ($urandom_range(0, 99) < pct) ? ~lvl : lvl;
	endfunction

	// gain is zero out of reset, so all samples come out silent
	task automatic test_quiet_after_reset();
		send_sample(1'b0, 1'b0, 16'sh8000, 16'sh7FFF, 1'b1);
		send_sample(1'b0, 1'b0, 16'sh7FFF, 16'sh8000, 1'b0);
		send_sample(1'b0, 1'b0, 16'shFFFF, 16'sh0000, 1'b1);
	endtask

	// linear ramp that ends after six samples, then the gain holds
	task automatic test_short_ramp();
		set_config(0, 32768, 10);
		send_sample(1'b1, 1'b0, 16'sh7FFF, 16'sh8000, 1'b1);
		send_sample(1'b1, 1'b0, 16'sh8000, 16'sh7FFF, 1'b1);
		send_sample(1'b1, 1'b0, 16'sh4000, 16'sh1234, 1'b0);
		send_sample(1'b1, 1'b0, 16'shC000, 16'sh7FFF, 1'b1);
		send_sample(1'b1, 1'b0, 16'sh7FFF, 16'sh8000, 1'b0);
		send_sample(1'b1, 1'b0, 16'sh8000, 16'sh7FFF, 1'b1);
		send_sample(1'b1, 1'b0, 16'sh7FFF, 16'sh8000, 1'b1);
		send_sample(1'b0, 1'b0, 16'sh8000, 16'sh7FFF, 1'b0);
	endtask

	// reset edge lights the led for rate/10 samples, both edges at once restart the ramp
	task automatic test_reset_flash();
		set_config(0, 32768, 25);
		send_sample(1'b0, 1'b1, 16'sh7FFF, 16'sh7FFF, 1'b1);
		send_sample(1'b0, 1'b1, 16'sh1000, 16'sh2000, 1'b1);
		send_sample(1'b0, 1'b0, 16'sh1000, 16'sh2000, 1'b1);
		send_sample(1'b1, 1'b1, 16'sh7FFF, 16'sh8000, 1'b1);
		send_sample(1'b1, 1'b1, 16'sh7FFF, 16'sh8000, 1'b0);
	endtask

	// fully inverse shape drives the blend below zero early in the ramp
	task automatic test_negative_gain();
		set_config(65535, 0, 1000);
		send_sample(1'b0, 1'b0, 16'sh7FFF, 16'sh8000, 1'b1);
		send_sample(1'b1, 1'b0, 16'sh7FFF, 16'sh8000, 1'b1);
		send_sample(1'b1, 1'b0, 16'sh8000, 16'sh7FFF, 1'b0);
		send_sample(1'b1, 1'b0, 16'sh7FFF, 16'sh7FFF, 1'b1);
	endtask

	// rate zero acts as one: no flash, the ramp ends at the first sample
	task automatic test_zero_rate();
		set_config(0, 65535, 0);
		send_sample(1'b0, 1'b0, 16'sh2222, 16'sh8000, 1'b1);
		send_sample(1'b0, 1'b1, 16'sh7FFF, 16'sh8000, 1'b1);
		send_sample(1'b1, 1'b1, 16'sh7FFF, 16'sh8000, 1'b0);
		send_sample(1'b1, 1'b0, 16'sh8000, 16'sh7FFF, 1'b1);
	endtask

	// receiver holds off for a long stretch while the sender keeps offering
	task automatic test_output_backpressure();
		set_config(2000, 40000, 120);
		quiet_mode   = 1'b1;
		hold_request = 300;
		repeat (30) begin
			fade_lvl = next_level(fade_lvl, 20);
			send_sample(fade_lvl, 1'b0, pick_sample(), pick_sample(), 1'($urandom()));
		end
		quiet_mode = 1'b0;
	endtask

	// mostly long ramps with rare presses, some noisy phases with many edges
	task automatic test_random_phases();
		int unsigned knob;
		int unsigned shape;
		int unsigned rate;
		bit          noisy;
		for (int ph = 0; ph < 10; ph++) begin
			knob  = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 3000) :
				$urandom_range(0, 65535);
			shape = $urandom_range(0, 65535);
			rate  = ($urandom_range(0, 3) == 0) ? $urandom_range(1000, 192000) :
				$urandom_range(2, 150);
			case (ph)
				0: begin
					knob  = 0;
					shape = 0;
					rate  = 100;
				end
				1: begin
					knob  = 65535;
					shape = 65535;
					rate  = 262143;
				end
				2: begin
					knob  = 0;
					shape = 65535;
					rate  = 0;
				end
				3: begin
					knob  = 65535;
					shape = 0;
					rate  = 1;
				end
				default: ;
			endcase
			set_config(knob, shape, rate);
			quiet_mode = (ph == 4 || ph == 7);
			noisy      = (ph % 3 == 2);
			repeat (100) begin
				fade_lvl  = next_level(fade_lvl, noisy ? 40 : 3);
				reset_lvl = next_level(reset_lvl, noisy ? 30 : 2);
				send_sample(fade_lvl, reset_lvl, pick_sample(), pick_sample(),
					1'($urandom()));
			end
		end
		quiet_mode = 1'b0;
	endtask

	// receiver: random stalls, long hold on request, no random stalls when quiet
	always @(negedge clk) begin
		if (hold_request != 0) begin
			stall_left   = hold_request;
			hold_request = 0;
		end
		if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left = stall_left - 1;
		end else begin
			out_ready <= 1'b1;
			if (!quiet_mode && $urandom_range(0, 99) < 25)
				stall_left = pick_gap();
		end
	end

	// each taken result against the oldest expectation
	always @(posedge clk) begin
		gain_result_t want;
		if (arst_n && out_valid === 1'b1 && out_ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result with nothing expected", 0, 0);
			end else begin
				want = pending_results.pop_front();
				if (left_out !== want.left_out)
					report_mismatch("left_out", left_out, want.left_out);
				if (right_out !== want.right_out)
					report_mismatch("right_out", right_out, want.right_out);
				if (gain_level !== want.gain_level)
					report_mismatch("gain_level", gain_level, want.gain_level);
				if (reset_led !== want.reset_led)
					report_mismatch("reset_led", reset_led, want.reset_led);
				if (fading !== want.fading)
					report_mismatch("fading", fading, want.fading);
			end
			result_count++;
		end
	end

	initial begin
		fill_log_curve();
		// reset asserted from time zero, released on a falling edge
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_quiet_after_reset();
		test_short_ramp();
		test_reset_flash();
		test_negative_gain();
		test_zero_rate();
		test_output_backpressure();
		test_random_phases();
		wait_drained();
		if (error_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

`default_nettype wire
